### hdl/mqf_pkg.sv
// Shared types and constants for the multi-queue linked-list FIFO.
package mqf_pkg;

  // Fixed payload widths of the request and result transactions
  localparam int OP_W      = 1;
  localparam int QIDX_W    = 3;
  localparam int CHAR_W    = 8;
  localparam int LEN_OUT_W = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH = 1'b0;
  localparam logic [OP_W-1:0] OP_POP  = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_COMMIT
  } mqf_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;     // request channel may accept
    logic capture;  // latch the request and launch the link read
    logic commit;   // apply the update and load the result register
  } mqf_cmd_t;

  // Status seen by the controller
  typedef struct packed {
    logic req_valid;    // a request is offered
    logic result_busy;  // result register holds a transaction not yet taken
  } mqf_status_t;

endpackage

### hdl/mqf_if.sv
// Request and result channel interfaces of the multi-queue FIFO.
interface mqf_in_if;
  logic                             valid;
  logic                             ready;
  logic [mqf_pkg::OP_W-1:0]         operation;
  logic [mqf_pkg::QIDX_W-1:0]       queue_index;
  logic [mqf_pkg::CHAR_W-1:0]       character;

  modport source (output valid, output operation, output queue_index, output character,
                  input ready);
  modport sink   (input valid, input operation, input queue_index, input character,
                  output ready);
endinterface

interface mqf_out_if;
  logic                             valid;
  logic                             ready;
  logic [mqf_pkg::CHAR_W-1:0]       front_character;
  logic                             queue_empty;
  logic [mqf_pkg::LEN_OUT_W-1:0]    queue_length;
  logic [mqf_pkg::LEN_OUT_W-1:0]    longest_length;
  logic                             push_dropped;

  modport source (output valid, output front_character, output queue_empty,
                  output queue_length, output longest_length, output push_dropped,
                  input ready);
  modport sink   (input valid, input front_character, input queue_empty,
                  input queue_length, input longest_length, input push_dropped,
                  output ready);
endinterface

### hdl/mqf_ctrl.sv
// Sequencing controller: accept, fetch, commit.
module mqf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  mqf_pkg::mqf_status_t status,
  output mqf_pkg::mqf_cmd_t   cmd
);

  mqf_pkg::mqf_state_t state;
  mqf_pkg::mqf_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mqf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      mqf_pkg::ST_IDLE: begin
        cmd.take = 1'b1;
        if (status.req_valid) begin
          cmd.capture = 1'b1;
          state_next  = mqf_pkg::ST_FETCH;
        end
      end
      mqf_pkg::ST_FETCH: begin
        // character read of the next link is in flight
        state_next = mqf_pkg::ST_COMMIT;
      end
      mqf_pkg::ST_COMMIT: begin
        if (!status.result_busy) begin
          cmd.commit = 1'b1;
          state_next = mqf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mqf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/mqf_datapath.sv
// Datapath: queue pointers, shared entry store, free list and result register.
module mqf_datapath #(
  parameter int NUM_QUEUES    = 5,
  parameter int STORE_ENTRIES = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mqf_pkg::mqf_cmd_t                cmd,
  output logic                             result_busy,
  input  logic [mqf_pkg::OP_W-1:0]         operation,
  input  logic [mqf_pkg::QIDX_W-1:0]       queue_index,
  input  logic [mqf_pkg::CHAR_W-1:0]       character,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic [mqf_pkg::CHAR_W-1:0]       front_character,
  output logic                             queue_empty,
  output logic [mqf_pkg::LEN_OUT_W-1:0]    queue_length,
  output logic [mqf_pkg::LEN_OUT_W-1:0]    longest_length,
  output logic                             push_dropped
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int EW = $clog2(STORE_ENTRIES);
  localparam int LW = $clog2(STORE_ENTRIES + 1);
  localparam int CW = mqf_pkg::CHAR_W;

  // Shared entry store
  logic [CW-1:0] chars_mem [STORE_ENTRIES];
  logic [EW-1:0] links_mem [STORE_ENTRIES];

  // Per-queue state
  logic [EW-1:0] q_head  [NUM_QUEUES];
  logic [EW-1:0] q_tail  [NUM_QUEUES];
  logic [LW-1:0] q_len   [NUM_QUEUES];
  logic [CW-1:0] q_front [NUM_QUEUES];

  // Entry allocation state
  logic [EW-1:0] free_head;
  logic [LW-1:0] free_count;
  logic [LW-1:0] fresh_count;
  logic [LW-1:0] longest;

  // Captured transaction and memory read data
  logic [mqf_pkg::OP_W-1:0] item_op;
  logic [QW-1:0]            item_q;
  logic                     item_qok;
  logic [CW-1:0]            item_ch;
  logic [EW-1:0]            link_rd;
  logic [CW-1:0]            chars_rd;

  // Request decode
  logic          in_qok;
  logic [QW-1:0] in_qsel;
  logic [EW-1:0] link_raddr;

  // Commit decode
  logic          is_push;
  logic          have_free;
  logic          have_fresh;
  logic [EW-1:0] new_entry;
  logic [LW-1:0] len_cur;
  logic          push_ok;
  logic          push_drop;
  logic          pop_ok;
  logic          others_at_max;
  logic [LW-1:0] res_len;
  logic [CW-1:0] res_front;
  logic [LW-1:0] longest_next;

  // Memory write port controls
  logic          chars_we;
  logic          links_we;
  logic [EW-1:0] links_waddr;
  logic [EW-1:0] links_wdata;

  // Request address: pop follows the head's link, push follows the free list
  always_comb begin
    in_qok     = int'(queue_index) < NUM_QUEUES;
    in_qsel    = in_qok ? QW'(queue_index) : '0;
    link_raddr = (operation == mqf_pkg::OP_POP) ? q_head[in_qsel] : free_head;
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_op  <= operation;
      item_q   <= in_qsel;
      item_qok <= in_qok;
      item_ch  <= character;
    end
  end

  // Allocation and result decode
  always_comb begin
    is_push    = item_op == mqf_pkg::OP_PUSH;
    have_free  = free_count != '0;
    have_fresh = fresh_count < LW'(STORE_ENTRIES);
    new_entry  = have_free ? free_head : fresh_count[EW-1:0];
    len_cur    = q_len[item_q];
    push_ok    = item_qok && is_push && (have_free || have_fresh);
    push_drop  = item_qok && is_push && !(have_free || have_fresh);
    pop_ok     = item_qok && !is_push && (len_cur != '0);

    // another queue also sits at the current maximum
    others_at_max = 1'b0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      if ((QW'(i) != item_q) && (q_len[i] == longest)) begin
        others_at_max = 1'b1;
      end
    end

    longest_next = longest;
    if (push_ok) begin
      res_len   = len_cur + LW'(1);
      res_front = (len_cur == '0) ? item_ch : q_front[item_q];
      if (res_len > longest) begin
        longest_next = res_len;
      end
    end else if (pop_ok) begin
      res_len   = len_cur - LW'(1);
      res_front = (res_len != '0) ? chars_rd : '0;
      if ((len_cur == longest) && !others_at_max) begin
        longest_next = longest - LW'(1);
      end
    end else if (item_qok) begin
      res_len   = len_cur;
      res_front = (len_cur != '0) ? q_front[item_q] : '0;
    end else begin
      res_len   = '0;
      res_front = '0;
    end

    chars_we    = cmd.commit && push_ok;
    links_we    = cmd.commit && ((push_ok && (len_cur != '0)) || pop_ok);
    links_waddr = pop_ok ? q_head[item_q] : q_tail[item_q];
    links_wdata = pop_ok ? free_head : new_entry;
  end

  // Entry store: one write and one registered read per memory
  always_ff @(posedge clk) begin
    if (chars_we) begin
      chars_mem[new_entry] <= item_ch;
    end
    chars_rd <= chars_mem[link_rd];
  end

  always_ff @(posedge clk) begin
    if (links_we) begin
      links_mem[links_waddr] <= links_wdata;
    end
    if (cmd.capture) begin
      link_rd <= links_mem[link_raddr];
    end
  end

  // Front byte cache per queue, meaningful only while the queue is non-empty
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (push_ok && (len_cur == '0)) begin
        q_front[item_q] <= item_ch;
      end else if (pop_ok && (res_len != '0)) begin
        q_front[item_q] <= chars_rd;
      end
    end
  end

  // Queue pointers, lengths and allocation state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        q_head[i] <= '0;
        q_tail[i] <= '0;
        q_len[i]  <= '0;
      end
      free_head   <= '0;
      free_count  <= '0;
      fresh_count <= '0;
      longest     <= '0;
    end else if (cmd.commit) begin
      longest <= longest_next;
      if (push_ok) begin
        if (have_free) begin
          free_head  <= link_rd;
          free_count <= free_count - LW'(1);
        end else begin
          fresh_count <= fresh_count + LW'(1);
        end
        if (len_cur == '0) begin
          q_head[item_q] <= new_entry;
        end
        q_tail[item_q] <= new_entry;
        q_len[item_q]  <= res_len;
      end else if (pop_ok) begin
        q_len[item_q] <= res_len;
        if (res_len == '0) begin
          q_head[item_q] <= '0;
          q_tail[item_q] <= '0;
        end else begin
          q_head[item_q] <= link_rd;
        end
        free_head  <= q_head[item_q];
        free_count <= free_count + LW'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      front_character <= res_front;
      queue_empty     <= res_len == '0;
      queue_length    <= mqf_pkg::LEN_OUT_W'(res_len);
      longest_length  <= mqf_pkg::LEN_OUT_W'(longest_next);
      push_dropped    <= push_drop;
    end
  end

  assign result_busy = res_valid && !res_ready;

endmodule

### hdl/multi_queue_fifo_with_max_length_unit.sv
// NUM_QUEUES byte FIFOs sharing a linked store of STORE_ENTRIES entries. Each request
// transaction pushes a byte onto, or pops the front of, the queue named by queue_index,
// and yields one result transaction with that queue's front byte (0 when empty), its
// empty flag and length, the longest length over all queues, and a flag for a push
// dropped because the store was full. A pop on an empty queue and an index at or above
// NUM_QUEUES change nothing. Each transaction passes through the link memory read, the
// dependent character memory read, then the commit of all updates; the next request is
// taken once the commit is done, even while the result still waits in its output
// register. Freed entries are reused through a free list, so no clearing pass is needed
// after reset.
module multi_queue_fifo_with_max_length_unit #(
  parameter int NUM_QUEUES    = 5,
  parameter int STORE_ENTRIES = 64
) (
  input logic      clk,
  input logic      rst,
  mqf_in_if.sink   request,
  mqf_out_if.source result
);

  mqf_pkg::mqf_cmd_t    cmd;
  mqf_pkg::mqf_status_t status;
  logic                 result_busy;

  assign request.ready      = cmd.take;
  assign status.req_valid   = request.valid;
  assign status.result_busy = result_busy;

  mqf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  mqf_datapath #(
    .NUM_QUEUES    (NUM_QUEUES),
    .STORE_ENTRIES (STORE_ENTRIES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .result_busy     (result_busy),
    .operation       (request.operation),
    .queue_index     (request.queue_index),
    .character       (request.character),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .front_character (result.front_character),
    .queue_empty     (result.queue_empty),
    .queue_length    (result.queue_length),
    .longest_length  (result.longest_length),
    .push_dropped    (result.push_dropped)
  );

endmodule

### hdl/mqf_checker.sv
// Port-level checker for the multi-queue FIFO, bound to the top level.
module mqf_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic res_valid,
  input logic res_ready
);

  // transactions accepted but not yet delivered
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({req_valid && req_ready, res_valid && res_ready})
        2'b10:   pending <= pending + 2'd1;
        2'b01:   pending <= pending - 2'd1;
        default: pending <= pending;
      endcase
    end
  end

  // one transaction in work at a time: no acceptance in the cycle after one
  a_single_in_work: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted back to back");

  // a result is only offered for an accepted request
  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (pending != 2'd0))
    else $error("result offered with no request outstanding");

  // at most one result waiting plus one in work
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    (pending != 2'd3))
    else $error("too many transactions outstanding");

  // a stalled result stays offered
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result withdrawn before it was taken");

endmodule

bind multi_queue_fifo_with_max_length_unit mqf_checker u_mqf_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (request.valid),
  .req_ready (request.ready),
  .res_valid (result.valid),
  .res_ready (result.ready)
);

### dv/multi_queue_fifo_with_max_length_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multi-queue linked-list FIFO with longest-length report.
module multi_queue_fifo_with_max_length_unit_test;

  localparam int NUM_QUEUES    = 5;
  localparam int STORE_ENTRIES = 64;
  localparam int ENTRY_W       = $clog2(STORE_ENTRIES);
  localparam int STALL_LIMIT   = 3000;
  localparam int SHOWN_ERRORS  = 10;

  // One status report as seen on the result channel
  typedef struct packed {
    logic [mqf_pkg::CHAR_W-1:0]    front_character;
    logic                          queue_empty;
    logic [mqf_pkg::LEN_OUT_W-1:0] queue_length;
    logic [mqf_pkg::LEN_OUT_W-1:0] longest_length;
    logic                          push_dropped;
  } queue_status_t;

  logic clk = 1'b0;
  logic rst;

  mqf_in_if  req_if ();
  mqf_out_if res_if ();

  multi_queue_fifo_with_max_length_unit #(
    .NUM_QUEUES    (NUM_QUEUES),
    .STORE_ENTRIES (STORE_ENTRIES)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the linked store (2-state, so it starts cleared)
  bit [mqf_pkg::CHAR_W-1:0]    entry_char [STORE_ENTRIES];
  bit [ENTRY_W-1:0]            entry_link [STORE_ENTRIES];
  bit [ENTRY_W-1:0]            head_ptr   [NUM_QUEUES];
  bit [ENTRY_W-1:0]            tail_ptr   [NUM_QUEUES];
  bit [mqf_pkg::LEN_OUT_W-1:0] queue_len  [NUM_QUEUES];
  bit [ENTRY_W-1:0]            free_head;
  bit [mqf_pkg::LEN_OUT_W-1:0] free_count;
  bit [mqf_pkg::LEN_OUT_W-1:0] fresh_count;

  queue_status_t pending_status [$];

  int errors;
  int shown_errors;
  int reports_checked;
  int pushes_sent, pops_sent, pushes_dropped, empty_pops, ignored_sent;
  int peak_longest;

  // Idling controls
  bit tx_gaps_on   = 1'b1;
  bit rx_stalls_on = 1'b1;
  int hold_request;

  // Applies one request to the shadow store and returns the status it yields
  function automatic queue_status_t apply_request(bit op, bit [mqf_pkg::QIDX_W-1:0] qi,
                                                  bit [mqf_pkg::CHAR_W-1:0] ch);
    queue_status_t r;
    bit [ENTRY_W-1:0] slot;
    bit got;
    r = '0;
    got = 1'b1;
    if (qi < NUM_QUEUES) begin
      if (op == mqf_pkg::OP_PUSH) begin
        // free list first, then never-used entries
        if (free_count != 0) begin
          slot = free_head;
          free_head = entry_link[slot];
          free_count--;
        end else if (fresh_count < STORE_ENTRIES) begin
          slot = fresh_count[ENTRY_W-1:0];
          fresh_count++;
        end else begin
          got = 1'b0;
        end
        if (got) begin
          entry_char[slot] = ch;
          entry_link[slot] = '0;
          if (queue_len[qi] == 0) head_ptr[qi] = slot;
          else entry_link[tail_ptr[qi]] = slot;
          tail_ptr[qi] = slot;
          queue_len[qi]++;
        end else begin
          r.push_dropped = 1'b1;
        end
      end else if (queue_len[qi] != 0) begin
        slot = head_ptr[qi];
        head_ptr[qi] = entry_link[slot];
        queue_len[qi]--;
        if (queue_len[qi] == 0) begin
          head_ptr[qi] = '0;
          tail_ptr[qi] = '0;
        end
        entry_link[slot] = free_head;
        free_head = slot;
        free_count++;
      end
      r.queue_length = queue_len[qi];
      if (queue_len[qi] != 0) r.front_character = entry_char[head_ptr[qi]];
    end
    r.queue_empty = (r.queue_length == 0);
    for (int i = 0; i < NUM_QUEUES; i++) begin
      if (queue_len[i] > r.longest_length) r.longest_length = queue_len[i];
    end
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly valid queues, some out-of-range indexes
  function automatic bit [mqf_pkg::QIDX_W-1:0] random_queue();
    if ($urandom_range(0, 99) < 7) return mqf_pkg::QIDX_W'($urandom_range(NUM_QUEUES, 7));
    return mqf_pkg::QIDX_W'($urandom_range(0, NUM_QUEUES - 1));
  endfunction

  // Random valid queue index
  function automatic bit [mqf_pkg::QIDX_W-1:0] valid_queue();
    return mqf_pkg::QIDX_W'($urandom_range(0, NUM_QUEUES - 1));
  endfunction

  // Random byte
  function automatic bit [mqf_pkg::CHAR_W-1:0] random_char();
    return mqf_pkg::CHAR_W'($urandom_range(0, 255));
  endfunction

  // Entries currently linked into some queue
  function automatic int entries_in_use();
    return int'(fresh_count - free_count);
  endfunction

  // Offers one request transaction; called and returns at a falling edge, valid left high
  task automatic send_request(bit op, bit [mqf_pkg::QIDX_W-1:0] qi,
                              bit [mqf_pkg::CHAR_W-1:0] ch);
    int gap;
    bit was_empty;
    queue_status_t want;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid       = 1'b1;
    req_if.operation   = op;
    req_if.queue_index = qi;
    req_if.character   = ch;
    do @(posedge clk); while (!req_if.ready);
    was_empty = 1'b0;
    if (qi < NUM_QUEUES) was_empty = (queue_len[qi] == 0);
    want = apply_request(op, qi, ch);
    pending_status.push_back(want);
    if (qi >= NUM_QUEUES) ignored_sent++;
    else if (op == mqf_pkg::OP_PUSH) pushes_sent++;
    else pops_sent++;
    if (want.push_dropped) pushes_dropped++;
    if (op == mqf_pkg::OP_POP && was_empty) empty_pops++;
    if (want.longest_length > peak_longest) peak_longest = int'(want.longest_length);
    @(negedge clk);
  endtask

  task automatic request_idle();
    req_if.valid = 1'b0;
  endtask

  // Extremes of every field, each operation, empty pops, out-of-range indexes
  task automatic test_directed();
    send_request(mqf_pkg::OP_POP,  3'd0, 8'h00);
    send_request(mqf_pkg::OP_PUSH, 3'd0, 8'h00);
    send_request(mqf_pkg::OP_PUSH, 3'd0, 8'hFF);
    send_request(mqf_pkg::OP_PUSH, 3'd4, 8'hA5);
    send_request(mqf_pkg::OP_PUSH, 3'd4, 8'h5A);
    send_request(mqf_pkg::OP_PUSH, 3'd1, 8'h01);
    send_request(mqf_pkg::OP_PUSH, 3'd2, 8'h80);
    send_request(mqf_pkg::OP_PUSH, 3'd3, 8'h7F);
    send_request(mqf_pkg::OP_PUSH, 3'd5, 8'hFF);
    send_request(mqf_pkg::OP_POP,  3'd6, 8'h00);
    send_request(mqf_pkg::OP_PUSH, 3'd7, 8'h00);
    send_request(mqf_pkg::OP_POP,  3'd7, 8'hFF);
    send_request(mqf_pkg::OP_POP,  3'd0, 8'h00);
    send_request(mqf_pkg::OP_POP,  3'd0, 8'h00);
    send_request(mqf_pkg::OP_POP,  3'd0, 8'h00);
    send_request(mqf_pkg::OP_POP,  3'd4, 8'h00);
    send_request(mqf_pkg::OP_POP,  3'd1, 8'h00);
    send_request(mqf_pkg::OP_POP,  3'd2, 8'h00);
    send_request(mqf_pkg::OP_POP,  3'd3, 8'h00);
    send_request(mqf_pkg::OP_POP,  3'd4, 8'h00);
    send_request(mqf_pkg::OP_POP,  3'd5, 8'h00);
  endtask

  // One queue takes the whole store, extra pushes get dropped, then it drains;
  // the receiver holds off meanwhile so the block backs up
  task automatic test_single_queue_full();
    bit [mqf_pkg::QIDX_W-1:0] q;
    q = valid_queue();
    tx_gaps_on = 1'b0;
    hold_request = 400;
    repeat (STORE_ENTRIES + 4) send_request(mqf_pkg::OP_PUSH, q, random_char());
    tx_gaps_on = 1'b1;
    repeat (STORE_ENTRIES + 1) send_request(mqf_pkg::OP_POP, q, random_char());
  endtask

  // Store filled across all queues, pause until drained, then random-order emptying
  task automatic test_spread_fill();
    repeat (STORE_ENTRIES + 6) begin
      send_request(mqf_pkg::OP_PUSH, valid_queue(), random_char());
    end
    request_idle();
    while (pending_status.size() != 0) @(negedge clk);
    while (entries_in_use() != 0) begin
      send_request(mqf_pkg::OP_POP, valid_queue(), random_char());
    end
  endtask

  // Random push/pop mix; the push share and the idling change every block
  task automatic test_random_mix();
    int push_pct;
    for (int blk = 0; blk < 11; blk++) begin
      push_pct     = $urandom_range(15, 85);
      tx_gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      repeat (50) begin
        send_request(($urandom_range(0, 99) < push_pct) ? mqf_pkg::OP_PUSH : mqf_pkg::OP_POP,
                     random_queue(), random_char());
      end
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Result-side ready: random stalls plus an occasional long hold-off
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready = 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
        res_if.ready = 1'b0;
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  // Compare each result transaction with the oldest expected status
  always @(posedge clk) begin : check_results
    queue_status_t seen;
    queue_status_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      seen.front_character = res_if.front_character;
      seen.queue_empty     = res_if.queue_empty;
      seen.queue_length    = res_if.queue_length;
      seen.longest_length  = res_if.longest_length;
      seen.push_dropped    = res_if.push_dropped;
      if (pending_status.size() == 0) begin
        errors++;
        if (shown_errors < SHOWN_ERRORS) begin
          shown_errors++;
          $display("ERROR %0t: result with nothing expected: front=%02h empty=%b len=%0d",
                   $realtime, seen.front_character, seen.queue_empty, seen.queue_length);
        end
      end else begin
        want = pending_status.pop_front();
        reports_checked++;
        if (seen.front_character !== want.front_character ||
            seen.queue_empty     !== want.queue_empty ||
            seen.queue_length    !== want.queue_length ||
            seen.longest_length  !== want.longest_length ||
            seen.push_dropped    !== want.push_dropped) begin
          errors++;
          if (shown_errors < SHOWN_ERRORS) begin
            shown_errors++;
            $display("ERROR %0t: report %0d expected front=%02h empty=%b len=%0d longest=%0d drop=%b",
                     $realtime, reports_checked, want.front_character, want.queue_empty,
                     want.queue_length, want.longest_length, want.push_dropped);
            $display("       got                   front=%02h empty=%b len=%0d longest=%0d drop=%b",
                     seen.front_character, seen.queue_empty, seen.queue_length,
                     seen.longest_length, seen.push_dropped);
          end
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either channel
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (rst) begin
      quiet_cycles = 0;
    end else if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ERROR %0t: no transaction for %0d cycles", $realtime, quiet_cycles);
        $display("multi_queue_fifo_with_max_length_unit_test failed");
        $finish;
      end
    end
  end

  // Test sequence
  initial begin
    rst = 1'b1;
    req_if.valid       = 1'b0;
    req_if.operation   = mqf_pkg::OP_PUSH;
    req_if.queue_index = '0;
    req_if.character   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_single_queue_full();
    test_spread_fill();
    test_random_mix();

    // drain, then give the pipeline time to show any stray result
    request_idle();
    while (pending_status.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (pending_status.size() != 0) errors++;

    $display("Covered %0d pushes (%0d dropped on a full store), %0d pops (%0d on empty queues),",
             pushes_sent, pushes_dropped, pops_sent, empty_pops);
    $display("%0d out-of-range requests; %0d reports checked, peak longest length %0d, %0d errors",
             ignored_sent, reports_checked, peak_longest, errors);
    if (errors == 0) begin
      $display("multi_queue_fifo_with_max_length_unit_test passed");
    end else begin
      $display("multi_queue_fifo_with_max_length_unit_test failed");
    end
    $finish;
  end

endmodule
